>>> design/tdp_pkg.sv
// shared types and constants for the trial division primality block
`default_nettype none

package tdp_pkg;

  // fixed constants of the test
  localparam int unsigned Two          = 2;
  localparam int unsigned FirstDivisor = 3;
  localparam int unsigned FirstSquare  = 9;
  localparam int unsigned DivisorStep  = 2;
  localparam int unsigned SquareStep   = 4;

  // result transaction carries one bit padded to one byte
  localparam int unsigned OutBits = 8;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture value, set divisor to three
    logic start_div; // clear remainder, arm bit counter
    logic div_step;  // one restoring remainder step
    logic advance;   // next odd divisor and its square
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic below_two;
    logic is_two;
    logic is_even;
    logic past_bound; // divisor squared exceeds value
    logic div_last;   // current step is the final remainder step
    logic rem_zero;
  } status_t;

endpackage

`default_nettype wire

>>> design/tdp_datapath.sv
// datapath: operand, odd divisor, its square and a bit-serial remainder unit
`default_nettype none

module tdp_datapath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire tdp_pkg::cmd_t         cmd_i,
  output tdp_pkg::status_t           status_o
);
  import tdp_pkg::*;

  // divisor never passes about sqrt(2^VALUE_BITS) + 2
  localparam int unsigned DivBits = (VALUE_BITS + 1) / 2 + 2;
  localparam int unsigned SqBits  = VALUE_BITS + 2;
  localparam int unsigned CntBits = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] value_q;
  logic [VALUE_BITS-1:0] shift_q;
  logic [DivBits-1:0]    div_q;
  logic [SqBits-1:0]     sq_q;
  logic [DivBits-1:0]    rem_q;
  logic [CntBits-1:0]    cnt_q;

  logic [DivBits:0]      trial;
  logic                  fits;
  logic [DivBits:0]      trial_sub;
  logic [DivBits-1:0]    rem_d;
  logic [SqBits-1:0]     sq_d;
  logic [DivBits-1:0]    div_d;

  // remainder stays below divisor, so it fits back into DivBits
  assign trial     = {rem_q, shift_q[VALUE_BITS-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};
  assign rem_d     = fits ? trial_sub[DivBits-1:0] : trial[DivBits-1:0];

  // (d+2)^2 = d^2 + 4d + 4
  assign sq_d  = sq_q + SqBits'({div_q, 2'b00}) + SqBits'(SquareStep);
  assign div_d = div_q + DivBits'(DivisorStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start_div) begin
      cnt_q <= CntBits'(VALUE_BITS);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      div_q   <= DivBits'(FirstDivisor);
      sq_q    <= SqBits'(FirstSquare);
    end else if (cmd_i.advance) begin
      div_q <= div_d;
      sq_q  <= sq_d;
    end
    if (cmd_i.start_div) begin
      rem_q   <= '0;
      shift_q <= value_q;
    end else if (cmd_i.div_step) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    status_o.below_two  = value_q < VALUE_BITS'(Two);
    status_o.is_two     = value_q == VALUE_BITS'(Two);
    status_o.is_even    = ~value_q[0];
    status_o.past_bound = sq_q > {2'b00, value_q};
    status_o.div_last   = cnt_q == CntBits'(1);
    status_o.rem_zero   = rem_q == '0;
  end

endmodule

`default_nettype wire

>>> design/tdp_controller.sv
// controller: sequences the trial divisions and holds the result register
`default_nettype none

module tdp_controller (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  out_prime_o,
  output tdp_pkg::cmd_t         cmd_o,
  input  wire tdp_pkg::status_t status_i
);
  import tdp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_TEST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;
  logic   out_valid_q, out_valid_d;
  logic   out_prime_q, out_prime_d;
  logic   slot_free;

  assign slot_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_prime_o = out_prime_q;

  always_comb begin
    state_d     = state_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_prime_d = out_prime_q;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.below_two) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (status_i.is_two) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else if (status_i.is_even) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (status_i.past_bound) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.rem_zero) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_prime_d = prime_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q     <= prime_d;
    out_prime_q <= out_prime_d;
  end

endmodule

`default_nettype wire

>>> design/trial_division_primality_top.sv
// top level of the trial division primality tester
//
// input stream: one transaction carries an unsigned value in s_axis_tdata_i,
//   the low VALUE_BITS bits are used, anything above is ignored
// output stream: one transaction per input, m_axis_tdata_o[0] is 1 when the
//   value is prime (2 counts as prime, 0 and 1 do not)
// timing: the accepting edge loads the operand; values below two, two itself
//   and even values go from the check state straight to the done state. each
//   odd divisor tried takes a bound check, VALUE_BITS restoring remainder
//   steps and a zero test; an odd value v is tried against the odd divisors
//   from 3 up to sqrt(v), about sqrt(v) / 2 of them, stopping at the first one
//   that divides it.
// one value is worked on at a time; s_axis_tready_o is high while idle,
//   even while a finished result waits in the output register
// if the receiver stalls, the result is held in m_axis_tdata_o and the next
//   value may still be computed; it then waits until the register frees
// reset clears the controller state and the output valid flag; no result is lost
//   or repeated across a stall
`default_nettype none

module trial_division_primality_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // slave side
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,  // value
  // master side
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [tdp_pkg::OutBits-1:0]              m_axis_tdata_o   // is_prime, zero pad
);
  import tdp_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    out_prime;

  // controller owns the handshakes and the result register
  tdp_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_prime_o (out_prime),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath sees only the low VALUE_BITS of the input transaction
  tdp_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (s_axis_tdata_i[VALUE_BITS-1:0]),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // result bit in the lowest position, padded to a whole byte
  assign m_axis_tdata_o = {{(OutBits-1){1'b0}}, out_prime};

endmodule

`default_nettype wire
